// ===== rtl/oli_pkg.sv =====
// Shared types, sizes and the ring address helper for the ordered list block.
`default_nettype none
package oli_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;

	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	typedef enum logic [1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_END   = 2'd1,
		CMD_DELETE    = 2'd2,
		CMD_READ_OUT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_READ,
		S_FIN
	} state_t;

	// Map a list offset to a ring position, wrapping at DEPTH.
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ordered_list_insert_delete.sv =====
// Top level: bounded ordered list kept as a ring in one synchronous memory.
//
// Usage:
//   Input channel (cmd, value, in_valid/in_ready) takes one command per transfer:
//   insert at front, insert at end, delete first match, or read out.
//   Output channel (status, item, last, occupancy, out_valid/out_ready) returns
//   one result per insert or delete, and one result per held entry for a read
//   out (a single empty result if the list holds nothing); last marks the final
//   result of a command.
//   Commands are taken one at a time: in_ready is high only while the sequencer
//   is idle, which it may be while a result still sits in the output register.
//   Sequence per command:
//     insert:   the entry is written on transfer, then the result is loaded.
//     delete:   a search reads entries in order until a match; a shift then
//               moves each later entry down one place to close the gap.
//     read out: one entry per cycle from the memory read port, holding while
//               the receiver stalls; the one registered read port sets the pace.
//   Reset returns the sequencer to idle and clears head, count and out_valid;
//   memory contents are not cleared and only live entries are ever used.
//   When the receiver stalls, the output register holds its result and the
//   sequencer waits before its next load, keeping pending read data in place.
`default_nettype none
module ordered_list_insert_delete (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [1:0]                        cmd,
	input  wire logic signed [oli_pkg::DW-1:0]     value,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	output logic [1:0]                             status,
	output logic signed [oli_pkg::DW-1:0]          item,
	output logic                                   last,
	output logic [oli_pkg::CW-1:0]                 occupancy,
	output logic                                   out_valid,
	input  wire logic                              out_ready
);

	localparam int AW = oli_pkg::AW;
	localparam int CW = oli_pkg::CW;
	localparam int DW = oli_pkg::DW;

	oli_pkg::state_t state_q, state_d;

	logic [DW-1:0] entries_q [oli_pkg::DEPTH];
	logic [DW-1:0] rdata_q;

	logic [AW-1:0]  head_q, head_d;
	logic [CW-1:0]  count_q, count_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic [DW-1:0]  val_q;
	oli_pkg::status_t fin_q, fin_d;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [DW-1:0]   item_q;
	logic            last_q;
	logic [CW-1:0]   occ_q;

	logic            accept;
	logic            emit_ok;
	logic            full;
	logic            empty;
	logic [CW-1:0]   idx_ext;
	logic            at_end;
	logic            shift_end;
	logic            hit;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [DW-1:0]   wr_data;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;

	logic            load_out;
	logic [1:0]      load_status;
	logic [DW-1:0]   load_item;
	logic            load_last;

	// Decode conditions shared by the state machine
	assign accept    = in_valid & in_ready;
	assign emit_ok   = !out_valid_q || out_ready;
	assign full      = (count_q == oli_pkg::CNT_FULL);
	assign empty     = (count_q == '0);
	assign idx_ext   = {{(CW-AW){1'b0}}, idx_q};
	assign at_end    = ((idx_ext + CW'(1)) == count_q);
	assign shift_end = ((idx_ext + CW'(2)) == count_q);
	assign hit       = (rdata_q == val_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			oli_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd)
						oli_pkg::CMD_DELETE:   state_d = empty ? oli_pkg::S_FIN
						                                       : oli_pkg::S_SEARCH;
						oli_pkg::CMD_READ_OUT: state_d = empty ? oli_pkg::S_FIN
						                                       : oli_pkg::S_READ;
						default:               state_d = oli_pkg::S_FIN;
					endcase
				end
			end
			oli_pkg::S_SEARCH: begin
				if (at_end) begin
					state_d = oli_pkg::S_FIN;
				end else if (hit) begin
					state_d = oli_pkg::S_SHIFT;
				end
			end
			oli_pkg::S_SHIFT: begin
				if (shift_end) begin
					state_d = oli_pkg::S_FIN;
				end
			end
			oli_pkg::S_READ: begin
				if (emit_ok && at_end) begin
					state_d = oli_pkg::S_IDLE;
				end
			end
			oli_pkg::S_FIN: begin
				if (emit_ok) begin
					state_d = oli_pkg::S_IDLE;
				end
			end
			default: state_d = oli_pkg::S_IDLE;
		endcase
	end

	// Datapath control per state
	always_comb begin
		in_ready    = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = val_q;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		load_out    = 1'b0;
		load_status = oli_pkg::ST_OK;
		load_item   = '0;
		load_last   = 1'b1;
		head_d      = head_q;
		count_d     = count_q;
		idx_d       = idx_q;
		fin_d       = fin_q;
		case (state_q)
			oli_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					idx_d   = '0;
					wr_data = value;
					case (cmd)
						oli_pkg::CMD_INS_FRONT, oli_pkg::CMD_INS_END: begin
							if (full) begin
								fin_d = oli_pkg::ST_FULL;
							end else begin
								fin_d   = oli_pkg::ST_OK;
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
								if (cmd == oli_pkg::CMD_INS_FRONT) begin
									head_d  = (head_q == '0) ? AW'(oli_pkg::DEPTH - 1)
									                         : head_q - AW'(1);
									wr_addr = head_d;
								end else begin
									wr_addr = oli_pkg::ring_pos(head_q, count_q[AW-1:0]);
								end
							end
						end
						default: begin
							// delete and read out start at the head entry
							fin_d = oli_pkg::ST_EMPTY;
							rd_en = !empty;
						end
					endcase
				end
			end
			oli_pkg::S_SEARCH: begin
				// compare the entry at idx_q, fetch the next one
				rd_en   = 1'b1;
				rd_addr = oli_pkg::ring_pos(head_q, idx_q + AW'(1));
				if (hit) begin
					fin_d = oli_pkg::ST_OK;
					if (at_end) begin
						count_d = count_q - CW'(1);
					end
				end else begin
					fin_d = oli_pkg::ST_NOTFOUND;
					idx_d = idx_q + AW'(1);
				end
			end
			oli_pkg::S_SHIFT: begin
				// move the entry at idx_q+1 down into idx_q
				wr_en   = 1'b1;
				wr_addr = oli_pkg::ring_pos(head_q, idx_q);
				wr_data = rdata_q;
				rd_en   = !shift_end;
				rd_addr = oli_pkg::ring_pos(head_q, idx_q + AW'(2));
				idx_d   = idx_q + AW'(1);
				if (shift_end) begin
					count_d = count_q - CW'(1);
				end
			end
			oli_pkg::S_READ: begin
				if (emit_ok) begin
					load_out    = 1'b1;
					load_item   = rdata_q;
					load_last   = at_end;
					rd_en       = !at_end;
					rd_addr     = oli_pkg::ring_pos(head_q, idx_q + AW'(1));
					idx_d       = idx_q + AW'(1);
				end
			end
			oli_pkg::S_FIN: begin
				if (emit_ok) begin
					load_out    = 1'b1;
					load_status = fin_q;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= entries_q[rd_addr];
		end
	end

	// Hold the command value for the search
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
		end
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oli_pkg::S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			fin_q   <= oli_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			fin_q   <= fin_d;
		end
	end

	// Output register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= load_status;
			item_q   <= load_item;
			last_q   <= load_last;
			occ_q    <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign last      = last_q;
	assign occupancy = occ_q;

endmodule
`default_nettype wire

// ===== rtl/oli_chk.sv =====
// Port-level checker for the ordered list block, bound to the top level.
`default_nettype none
module oli_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic [1:0]                    status,
	input wire logic signed [oli_pkg::DW-1:0] item,
	input wire logic                          last,
	input wire logic [oli_pkg::CW-1:0]        occupancy,
	input wire logic                          out_valid,
	input wire logic                          out_ready
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(item)
			&& $stable(last) && $stable(occupancy))
		else $error("stalled result changed");

	// Keep occupancy within the ring
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= oli_pkg::CNT_FULL)
		else $error("occupancy beyond depth");

	// Drop an insert only when full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == oli_pkg::ST_FULL |-> occupancy == oli_pkg::CNT_FULL)
		else $error("full status with room left");

	// Report empty only with nothing held
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == oli_pkg::ST_EMPTY |-> occupancy == '0)
		else $error("empty status with entries held");

	// Error results are single, final and carry no item
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != oli_pkg::ST_OK |-> last && item == '0)
		else $error("error result malformed");

endmodule

bind ordered_list_insert_delete oli_chk u_oli_chk (.*);
`default_nettype wire
